// ----- rtl/core/sqlsplit_pkg.sv -----
`timescale 1ns / 1ps

package sqlsplit_pkg;

  localparam int SPACE_DEPTH = 32;
  localparam int SP_PTR_W    = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int SP_CNT_W    = $clog2(SPACE_DEPTH + 1);
  localparam int SP_SUM_W    = SP_CNT_W + 1;

  localparam int CMD_SLOTS   = 3;
  localparam int SLOT_W      = 2;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    LEX_NORMAL,
    LEX_DASH,
    LEX_SLASH,
    LEX_LINE,
    LEX_BLOCK,
    LEX_BLOCK_STAR,
    LEX_SQ,
    LEX_SQ_CLOSE,
    LEX_DQ,
    LEX_DQ_CLOSE
  } lex_mode_t;

  typedef enum logic {
    CMD_APPEND,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  typedef enum logic [2:0] {
    TR_IDLE,
    TR_FETCH,
    TR_SPACE,
    TR_BYTE,
    TR_END
  } trim_state_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic cmd_t mk_cmd(input cmd_kind_t kind, input logic [7:0] data,
                                  input logic last);
    cmd_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    return r;
  endfunction

endpackage

// ----- rtl/core/sqlsplit_if.sv -----
`timescale 1ns / 1ps

interface sqlsplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] script_byte;
  logic       is_final;

  modport source (output valid, output script_byte, output is_final, input ready);
  modport sink   (input valid, input script_byte, input is_final, output ready);
endinterface

interface sqlsplit_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       statement_end;
  logic       trim_overflow;
  logic       last_result;

  modport source (output valid, output out_byte, output byte_valid, output statement_end,
                  output trim_overflow, output last_result, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input statement_end,
                  input trim_overflow, input last_result, output ready);
endinterface

// ----- rtl/core/sqlsplit_lexer.sv -----
`timescale 1ns / 1ps

module sqlsplit_lexer (
  input  logic                 clk,
  input  logic                 rst_n,
  sqlsplit_in_if.sink          in_chan,
  output logic                 push_valid,
  input  logic                 push_ready,
  output sqlsplit_pkg::cmd_t   push_cmd
);

  localparam int SLOT_W_L = sqlsplit_pkg::SLOT_W;

  sqlsplit_pkg::lex_mode_t mode_r, mode_nxt;
  logic                    started_r, started_nxt;
  logic [SLOT_W_L-1:0]     pend_r, pend_nxt;
  logic [SLOT_W_L-1:0]     idx_r, idx_nxt;
  sqlsplit_pkg::cmd_t      lst_r [sqlsplit_pkg::CMD_SLOTS];

  sqlsplit_pkg::lex_mode_t dec_mode;
  sqlsplit_pkg::cmd_t      dec_lst [sqlsplit_pkg::CMD_SLOTS];
  logic [SLOT_W_L-1:0]     dec_n;
  logic                    dec_st;
  logic                    do_norm;
  logic                    mid_seen;
  logic                    mid_st;
  logic [SLOT_W_L-1:0]     mid_idx;
  logic                    fin_st;
  logic [7:0]              c;
  logic                    accept;

  assign in_chan.ready = (pend_r == '0);
  assign accept        = in_chan.valid && in_chan.ready;
  assign push_valid    = (pend_r != '0);
  assign push_cmd      = lst_r[idx_r];
  assign c             = in_chan.script_byte;

  // byte decode into up to three commands
  always_comb begin
    dec_mode = mode_r;
    dec_n    = '0;
    dec_st   = started_r;
    do_norm  = 1'b0;
    mid_seen = 1'b0;
    mid_st   = 1'b0;
    mid_idx  = '0;
    fin_st   = 1'b0;
    for (int i = 0; i < sqlsplit_pkg::CMD_SLOTS; i++) begin
      dec_lst[i] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_END, 8'h00, 1'b0);
    end

    case (mode_r)
      sqlsplit_pkg::LEX_DASH: begin
        if (c == sqlsplit_pkg::CH_DASH) begin
          dec_mode = sqlsplit_pkg::LEX_LINE;
        end else begin
          dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND,
                                                sqlsplit_pkg::CH_DASH, 1'b0);
          dec_n  = dec_n + 1'b1;
          dec_st = 1'b1;
          do_norm = 1'b1;
        end
      end
      sqlsplit_pkg::LEX_SLASH: begin
        if (c == sqlsplit_pkg::CH_STAR) begin
          dec_mode = sqlsplit_pkg::LEX_BLOCK;
        end else begin
          dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND,
                                                sqlsplit_pkg::CH_SLASH, 1'b0);
          dec_n  = dec_n + 1'b1;
          dec_st = 1'b1;
          do_norm = 1'b1;
        end
      end
      sqlsplit_pkg::LEX_LINE: begin
        if (c == sqlsplit_pkg::CH_NL) begin
          dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND, c, 1'b0);
          dec_n    = dec_n + 1'b1;
          dec_mode = sqlsplit_pkg::LEX_NORMAL;
        end
      end
      sqlsplit_pkg::LEX_BLOCK: begin
        if (c == sqlsplit_pkg::CH_STAR) begin
          dec_mode = sqlsplit_pkg::LEX_BLOCK_STAR;
        end
      end
      sqlsplit_pkg::LEX_BLOCK_STAR: begin
        if (c == sqlsplit_pkg::CH_SLASH) begin
          dec_mode = sqlsplit_pkg::LEX_NORMAL;
        end else if (c != sqlsplit_pkg::CH_STAR) begin
          dec_mode = sqlsplit_pkg::LEX_BLOCK;
        end
      end
      sqlsplit_pkg::LEX_SQ: begin
        dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND, c, 1'b0);
        dec_n = dec_n + 1'b1;
        if (!sqlsplit_pkg::is_space(c)) begin
          dec_st = 1'b1;
        end
        if (c == sqlsplit_pkg::CH_SQUOTE) begin
          dec_mode = sqlsplit_pkg::LEX_SQ_CLOSE;
        end
      end
      sqlsplit_pkg::LEX_SQ_CLOSE: begin
        if (c == sqlsplit_pkg::CH_SQUOTE) begin
          dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND, c, 1'b0);
          dec_n    = dec_n + 1'b1;
          dec_st   = 1'b1;
          dec_mode = sqlsplit_pkg::LEX_SQ;
        end else begin
          do_norm = 1'b1;
        end
      end
      sqlsplit_pkg::LEX_DQ: begin
        dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND, c, 1'b0);
        dec_n = dec_n + 1'b1;
        if (!sqlsplit_pkg::is_space(c)) begin
          dec_st = 1'b1;
        end
        if (c == sqlsplit_pkg::CH_DQUOTE) begin
          dec_mode = sqlsplit_pkg::LEX_DQ_CLOSE;
        end
      end
      sqlsplit_pkg::LEX_DQ_CLOSE: begin
        if (c == sqlsplit_pkg::CH_DQUOTE) begin
          dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND, c, 1'b0);
          dec_n    = dec_n + 1'b1;
          dec_st   = 1'b1;
          dec_mode = sqlsplit_pkg::LEX_DQ;
        end else begin
          do_norm = 1'b1;
        end
      end
      default: begin
        do_norm = 1'b1;
      end
    endcase

    if (do_norm) begin
      dec_mode = sqlsplit_pkg::LEX_NORMAL;
      case (c)
        sqlsplit_pkg::CH_DASH: begin
          dec_mode = sqlsplit_pkg::LEX_DASH;
        end
        sqlsplit_pkg::CH_SLASH: begin
          dec_mode = sqlsplit_pkg::LEX_SLASH;
        end
        sqlsplit_pkg::CH_SQUOTE: begin
          dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND, c, 1'b0);
          dec_n    = dec_n + 1'b1;
          dec_st   = 1'b1;
          dec_mode = sqlsplit_pkg::LEX_SQ;
        end
        sqlsplit_pkg::CH_DQUOTE: begin
          dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND, c, 1'b0);
          dec_n    = dec_n + 1'b1;
          dec_st   = 1'b1;
          dec_mode = sqlsplit_pkg::LEX_DQ;
        end
        sqlsplit_pkg::CH_SEMI: begin
          mid_seen = 1'b1;
          mid_st   = dec_st;
          mid_idx  = dec_n;
          dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_END, 8'h00, 1'b0);
          dec_n  = dec_n + 1'b1;
          dec_st = 1'b0;
        end
        default: begin
          dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND, c, 1'b0);
          dec_n = dec_n + 1'b1;
          if (!sqlsplit_pkg::is_space(c)) begin
            dec_st = 1'b1;
          end
        end
      endcase
    end

    if (in_chan.is_final) begin
      // held dash or slash goes out as a plain byte
      if (dec_mode == sqlsplit_pkg::LEX_DASH) begin
        dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND,
                                              sqlsplit_pkg::CH_DASH, 1'b0);
        dec_n  = dec_n + 1'b1;
        dec_st = 1'b1;
      end else if (dec_mode == sqlsplit_pkg::LEX_SLASH) begin
        dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_APPEND,
                                              sqlsplit_pkg::CH_SLASH, 1'b0);
        dec_n  = dec_n + 1'b1;
        dec_st = 1'b1;
      end
      fin_st = dec_st;
      // last flag goes on the last end marker that really produces a result
      dec_lst[dec_n] = sqlsplit_pkg::mk_cmd(sqlsplit_pkg::CMD_END, 8'h00,
                                            fin_st || !(mid_seen && mid_st));
      dec_n = dec_n + 1'b1;
      if (!fin_st && mid_seen && mid_st) begin
        dec_lst[mid_idx].last = 1'b1;
      end
      dec_mode = sqlsplit_pkg::LEX_NORMAL;
      dec_st   = 1'b0;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    started_nxt = started_r;
    pend_nxt    = pend_r;
    idx_nxt     = idx_r;
    if (accept) begin
      mode_nxt    = dec_mode;
      started_nxt = dec_st;
      pend_nxt    = dec_n;
      idx_nxt     = '0;
    end else if (push_valid && push_ready) begin
      pend_nxt = pend_r - 1'b1;
      idx_nxt  = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= sqlsplit_pkg::LEX_NORMAL;
      started_r <= 1'b0;
      pend_r    <= '0;
      idx_r     <= '0;
    end else begin
      mode_r    <= mode_nxt;
      started_r <= started_nxt;
      pend_r    <= pend_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lst_r <= dec_lst;
    end
  end

endmodule

// ----- rtl/core/sqlsplit_fifo.sv -----
`timescale 1ns / 1ps

module sqlsplit_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  sqlsplit_pkg::cmd_t  push_cmd,
  output logic                pop_valid,
  input  logic                pop_ready,
  output sqlsplit_pkg::cmd_t  pop_cmd
);

  sqlsplit_pkg::cmd_t                    mem_r [sqlsplit_pkg::FIFO_DEPTH];
  logic [sqlsplit_pkg::FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sqlsplit_pkg::FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sqlsplit_pkg::FIFO_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                                  do_push;
  logic                                  do_pop;

  assign push_ready = (cnt_r != sqlsplit_pkg::FIFO_CNT_W'(sqlsplit_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/sqlsplit_trim.sv -----
`timescale 1ns / 1ps

module sqlsplit_trim (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  sqlsplit_pkg::cmd_t  pop_cmd,
  sqlsplit_out_if.source      out_chan
);

  localparam int PTR_W = sqlsplit_pkg::SP_PTR_W;
  localparam int CNT_W = sqlsplit_pkg::SP_CNT_W;
  localparam int SUM_W = sqlsplit_pkg::SP_SUM_W;
  localparam int DEPTH = sqlsplit_pkg::SPACE_DEPTH;

  logic [7:0]               mem_r [DEPTH];
  logic [7:0]               rdata_r;

  sqlsplit_pkg::trim_state_t state_r, state_nxt;
  sqlsplit_pkg::cmd_t        cmd_r, cmd_nxt;
  logic                      started_r, started_nxt;
  logic [PTR_W-1:0]          head_r, head_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_byte_r, out_byte_nxt;
  logic                      byte_valid_r, byte_valid_nxt;
  logic                      end_r, end_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      last_r, last_nxt;

  logic                      out_free;
  logic                      mem_we;
  logic [PTR_W-1:0]          mem_waddr;
  logic [7:0]                mem_wdata;
  logic [SUM_W-1:0]          tail_sum;
  logic [PTR_W-1:0]          tail;
  logic [PTR_W-1:0]          head_inc;
  logic                      full;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign pop_ready = (state_r == sqlsplit_pkg::TR_IDLE);
  assign full      = (cnt_r == CNT_W'(DEPTH));

  assign tail_sum = SUM_W'(head_r) + SUM_W'(cnt_r);
  assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                : PTR_W'(tail_sum);
  assign head_inc = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_byte      = out_byte_r;
  assign out_chan.byte_valid    = byte_valid_r;
  assign out_chan.statement_end = end_r;
  assign out_chan.trim_overflow = ovf_r;
  assign out_chan.last_result   = last_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sqlsplit_pkg::TR_IDLE: begin
        if (pop_valid) begin
          if (pop_cmd.kind == sqlsplit_pkg::CMD_APPEND) begin
            if (sqlsplit_pkg::is_space(pop_cmd.data)) begin
              if (started_r && full) begin
                state_nxt = sqlsplit_pkg::TR_FETCH;
              end
            end else if (cnt_r != '0) begin
              state_nxt = sqlsplit_pkg::TR_FETCH;
            end else begin
              state_nxt = sqlsplit_pkg::TR_BYTE;
            end
          end else if (started_r || pop_cmd.last) begin
            state_nxt = sqlsplit_pkg::TR_END;
          end
        end
      end
      sqlsplit_pkg::TR_FETCH: begin
        state_nxt = sqlsplit_pkg::TR_SPACE;
      end
      sqlsplit_pkg::TR_SPACE: begin
        if (out_free) begin
          if (sqlsplit_pkg::is_space(cmd_r.data)) begin
            state_nxt = sqlsplit_pkg::TR_IDLE;
          end else if (cnt_r == CNT_W'(1)) begin
            state_nxt = sqlsplit_pkg::TR_BYTE;
          end else begin
            state_nxt = sqlsplit_pkg::TR_FETCH;
          end
        end
      end
      sqlsplit_pkg::TR_BYTE: begin
        if (out_free) begin
          state_nxt = sqlsplit_pkg::TR_IDLE;
        end
      end
      sqlsplit_pkg::TR_END: begin
        if (out_free) begin
          state_nxt = sqlsplit_pkg::TR_IDLE;
        end
      end
      default: begin
        state_nxt = sqlsplit_pkg::TR_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_nxt        = cmd_r;
    started_nxt    = started_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_byte_nxt   = out_byte_r;
    byte_valid_nxt = byte_valid_r;
    end_nxt        = end_r;
    ovf_nxt        = ovf_r;
    last_nxt       = last_r;
    mem_we         = 1'b0;
    mem_waddr      = tail;
    mem_wdata      = pop_cmd.data;

    case (state_r)
      sqlsplit_pkg::TR_IDLE: begin
        if (pop_valid) begin
          cmd_nxt = pop_cmd;
          if (pop_cmd.kind == sqlsplit_pkg::CMD_APPEND) begin
            if (sqlsplit_pkg::is_space(pop_cmd.data)) begin
              if (started_r && !full) begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end else begin
              started_nxt = 1'b1;
            end
          end else if (!(started_r || pop_cmd.last)) begin
            cnt_nxt = '0;
          end
        end
      end
      sqlsplit_pkg::TR_SPACE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = rdata_r;
          byte_valid_nxt = 1'b1;
          end_nxt        = 1'b0;
          ovf_nxt        = sqlsplit_pkg::is_space(cmd_r.data);
          last_nxt       = 1'b0;
          head_nxt       = head_inc;
          if (sqlsplit_pkg::is_space(cmd_r.data)) begin
            // oldest slot is freed and takes the new byte
            mem_we    = 1'b1;
            mem_waddr = head_r;
            mem_wdata = cmd_r.data;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      sqlsplit_pkg::TR_BYTE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = cmd_r.data;
          byte_valid_nxt = 1'b1;
          end_nxt        = 1'b0;
          ovf_nxt        = 1'b0;
          last_nxt       = 1'b0;
        end
      end
      sqlsplit_pkg::TR_END: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = 8'h00;
          byte_valid_nxt = 1'b0;
          end_nxt        = started_r;
          ovf_nxt        = 1'b0;
          last_nxt       = cmd_r.last;
          started_nxt    = 1'b0;
          cnt_nxt        = '0;
        end
      end
      default: begin
        cmd_nxt = cmd_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqlsplit_pkg::TR_IDLE;
      started_r   <= 1'b0;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    out_byte_r   <= out_byte_nxt;
    byte_valid_r <= byte_valid_nxt;
    end_r        <= end_nxt;
    ovf_r        <= ovf_nxt;
    last_r       <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem_r[head_r];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("trailing space count above depth");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sqlsplit_pkg::TR_END && out_free) |=> (!started_r && cnt_r == '0))
    else $error("statement end left trailing state behind");

  a_byte_or_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(byte_valid_r && end_r))
    else $error("result carries both a byte and an end marker");

  a_ovf_space: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> (byte_valid_r && sqlsplit_pkg::is_space(out_byte_r)))
    else $error("overflow flag on a non-whitespace result");

endmodule

// ----- rtl/core/sql_statement_splitter_top.sv -----
`timescale 1ns / 1ps

// sql statement splitter
// in_chan: one script byte per transfer, is_final on the last byte of a script.
// out_chan: one result per transfer: a statement byte (byte_valid), a statement
// end marker (statement_end), trim_overflow on a whitespace byte pushed out of
// a full trailing buffer, and last_result on the final result of a script.
// the lexer takes a byte and then pushes each command it derives (up to three)
// before it takes the next byte; a comment byte derives none.
// commands pass a 4-entry queue to the trim unit, which pops each command and
// outputs each plain byte or end marker from a state of its own, only buffers
// whitespace that may be trailing, and when a statement resumes sends each
// buffered whitespace byte through a fetch and a space state, since each one is
// read from the 32-entry buffer memory with a registered read. a result passes
// the lexer commands, the queue and the trim unit before its output register.
// reset clears the lexer, the queue, the trim unit and the output register;
// the whitespace buffer needs no clearing.
// when the receiver stalls, the output register holds its result, the trim
// unit and queue fill, and in_chan.ready drops once the lexer cannot push.

module sql_statement_splitter_top (
  input  logic            clk,
  input  logic            rst_n,
  sqlsplit_in_if.sink     in_chan,
  sqlsplit_out_if.source  out_chan
);

  logic               lx_valid;
  logic               lx_ready;
  sqlsplit_pkg::cmd_t lx_cmd;
  logic               q_valid;
  logic               q_ready;
  sqlsplit_pkg::cmd_t q_cmd;

  sqlsplit_lexer u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (lx_valid),
    .push_ready (lx_ready),
    .push_cmd   (lx_cmd)
  );

  sqlsplit_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (lx_valid),
    .push_ready (lx_ready),
    .push_cmd   (lx_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  sqlsplit_trim u_trim (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd),
    .out_chan   (out_chan)
  );

endmodule

// ----- test/sqlsplit_checker.sv -----
`timescale 1ns / 1ps

module sqlsplit_checker (
  input  logic    clk,
  input  logic    rst_n,
  sqlsplit_in_if  in_mon,
  sqlsplit_out_if out_mon,
  output int      fail_count,
  output int      results_due
);

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       stmt_end;
    logic       overflow;
    logic       last_res;
  } split_result_t;

  split_result_t           due_q[$];
  sqlsplit_pkg::lex_mode_t mode;
  logic                    started;
  logic [7:0]              trail_ws[$];
  int                      fail_total;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == sqlsplit_pkg::CH_SPACE) ||
           ((c >= sqlsplit_pkg::CH_TAB) && (c <= sqlsplit_pkg::CH_CR));
  endfunction

  function automatic void emit(input logic [7:0] b, input logic valid, input logic fin_mark,
                               input logic ovf);
    split_result_t r;
    r.data       = valid ? b : 8'h00;
    r.byte_valid = valid;
    r.stmt_end   = fin_mark;
    r.overflow   = ovf;
    r.last_res   = 1'b0;
    due_q.push_back(r);
  endfunction

  // whitespace waits until a non-blank byte proves it is not trailing
  function automatic void take_char(input logic [7:0] c);
    if (blank_char(c)) begin
      if (!started) return;
      if (trail_ws.size() >= sqlsplit_pkg::SPACE_DEPTH)
        emit(trail_ws.pop_front(), 1'b1, 1'b0, 1'b1);
      trail_ws.push_back(c);
    end else begin
      started = 1'b1;
      foreach (trail_ws[i]) emit(trail_ws[i], 1'b1, 1'b0, 1'b0);
      trail_ws.delete();
      emit(c, 1'b1, 1'b0, 1'b0);
    end
  endfunction

  function automatic void close_statement();
    if (started) emit(8'h00, 1'b0, 1'b1, 1'b0);
    started = 1'b0;
    trail_ws.delete();
  endfunction

  function automatic void plain_char(input logic [7:0] c);
    case (c)
      sqlsplit_pkg::CH_DASH:   mode = sqlsplit_pkg::LEX_DASH;
      sqlsplit_pkg::CH_SLASH:  mode = sqlsplit_pkg::LEX_SLASH;
      sqlsplit_pkg::CH_SQUOTE: begin
        take_char(c);
        mode = sqlsplit_pkg::LEX_SQ;
      end
      sqlsplit_pkg::CH_DQUOTE: begin
        take_char(c);
        mode = sqlsplit_pkg::LEX_DQ;
      end
      sqlsplit_pkg::CH_SEMI:   close_statement();
      default:                 take_char(c);
    endcase
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    case (mode)
      sqlsplit_pkg::LEX_DASH: begin
        if (c == sqlsplit_pkg::CH_DASH) begin
          mode = sqlsplit_pkg::LEX_LINE;
        end else begin
          take_char(sqlsplit_pkg::CH_DASH);
          mode = sqlsplit_pkg::LEX_NORMAL;
          plain_char(c);
        end
      end
      sqlsplit_pkg::LEX_SLASH: begin
        if (c == sqlsplit_pkg::CH_STAR) begin
          mode = sqlsplit_pkg::LEX_BLOCK;
        end else begin
          take_char(sqlsplit_pkg::CH_SLASH);
          mode = sqlsplit_pkg::LEX_NORMAL;
          plain_char(c);
        end
      end
      sqlsplit_pkg::LEX_LINE: begin
        if (c == sqlsplit_pkg::CH_NL) begin
          take_char(c);
          mode = sqlsplit_pkg::LEX_NORMAL;
        end
      end
      sqlsplit_pkg::LEX_BLOCK: begin
        if (c == sqlsplit_pkg::CH_STAR) mode = sqlsplit_pkg::LEX_BLOCK_STAR;
      end
      sqlsplit_pkg::LEX_BLOCK_STAR: begin
        if (c == sqlsplit_pkg::CH_SLASH) mode = sqlsplit_pkg::LEX_NORMAL;
        else if (c != sqlsplit_pkg::CH_STAR) mode = sqlsplit_pkg::LEX_BLOCK;
      end
      sqlsplit_pkg::LEX_SQ: begin
        take_char(c);
        if (c == sqlsplit_pkg::CH_SQUOTE) mode = sqlsplit_pkg::LEX_SQ_CLOSE;
      end
      sqlsplit_pkg::LEX_SQ_CLOSE: begin
        if (c == sqlsplit_pkg::CH_SQUOTE) begin
          take_char(c);
          mode = sqlsplit_pkg::LEX_SQ;
        end else begin
          mode = sqlsplit_pkg::LEX_NORMAL;
          plain_char(c);
        end
      end
      sqlsplit_pkg::LEX_DQ: begin
        take_char(c);
        if (c == sqlsplit_pkg::CH_DQUOTE) mode = sqlsplit_pkg::LEX_DQ_CLOSE;
      end
      sqlsplit_pkg::LEX_DQ_CLOSE: begin
        if (c == sqlsplit_pkg::CH_DQUOTE) begin
          take_char(c);
          mode = sqlsplit_pkg::LEX_DQ;
        end else begin
          mode = sqlsplit_pkg::LEX_NORMAL;
          plain_char(c);
        end
      end
      default: begin
        mode = sqlsplit_pkg::LEX_NORMAL;
        plain_char(c);
      end
    endcase
  endfunction

  function automatic void split_byte(input logic [7:0] c, input logic fin);
    int            n0;
    split_result_t r;
    n0 = due_q.size();
    scan_char(c);
    if (fin) begin
      if (mode == sqlsplit_pkg::LEX_DASH) take_char(sqlsplit_pkg::CH_DASH);
      else if (mode == sqlsplit_pkg::LEX_SLASH) take_char(sqlsplit_pkg::CH_SLASH);
      close_statement();
      if (due_q.size() == n0) emit(8'h00, 1'b0, 1'b0, 1'b0);
      r = due_q.pop_back();
      r.last_res = 1'b1;
      due_q.push_back(r);
      mode    = sqlsplit_pkg::LEX_NORMAL;
      started = 1'b0;
      trail_ws.delete();
    end
  endfunction

  always @(posedge clk) begin : watch
    split_result_t got;
    split_result_t want;
    if (!rst_n) begin
      due_q.delete();
      trail_ws.delete();
      mode       = sqlsplit_pkg::LEX_NORMAL;
      started    = 1'b0;
      fail_total = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) split_byte(in_mon.script_byte, in_mon.is_final);
      if (out_mon.valid && out_mon.ready) begin
        got.data       = out_mon.out_byte;
        got.byte_valid = out_mon.byte_valid;
        got.stmt_end   = out_mon.statement_end;
        got.overflow   = out_mon.trim_overflow;
        got.last_res   = out_mon.last_result;
        if (due_q.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected transfer: expected none, actual %02h/%b/%b/%b/%b",
                   $time, got.data, got.byte_valid, got.stmt_end, got.overflow,
                   got.last_res);
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            fail_total++;
            $display("%0t: mismatch: expected %02h/%b/%b/%b/%b, actual %02h/%b/%b/%b/%b",
                     $time, want.data, want.byte_valid, want.stmt_end, want.overflow,
                     want.last_res, got.data, got.byte_valid, got.stmt_end, got.overflow,
                     got.last_res);
          end
        end
      end
    end
    fail_count  <= fail_total;
    results_due <= due_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  logic       clk = 1'b0;
  logic       rst_n;
  int         idle_pct;
  int         stall_pct;
  int         bytes_sent;
  int         fail_count;
  int         results_due;
  logic [7:0] script_q[$];

  sqlsplit_in_if  in_chan ();
  sqlsplit_out_if out_chan ();

  sql_statement_splitter_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sqlsplit_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_chan.valid       <= 1'b1;
    in_chan.script_byte <= b;
    in_chan.is_final    <= fin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic send_script();
    foreach (script_q[i]) send_byte(script_q[i], i == script_q.size() - 1);
    script_q.delete();
  endtask

  // hold off until every expected transfer has come out
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? sqlsplit_pkg::CH_SPACE : 8'(sqlsplit_pkg::CH_TAB + r);
  endfunction

  function automatic logic [7:0] pick_other(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == avoid);
    return b;
  endfunction

  function automatic void add_token();
    int roll;
    int len;
    logic [7:0] q;
    roll = $urandom_range(99);
    len  = $urandom_range(4);
    if (roll < 25) begin
      for (int k = 0; k <= len; k++)
        script_q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                                    : 8'($urandom_range(8'h61, 8'h7A)));
    end else if (roll < 40) begin
      // long runs overflow the trailing whitespace buffer
      if ($urandom_range(11) == 0)
        len = $urandom_range(sqlsplit_pkg::SPACE_DEPTH + 1, sqlsplit_pkg::SPACE_DEPTH + 8);
      for (int k = 0; k <= len; k++) script_q.push_back(pick_blank());
    end else if (roll < 55) begin
      q = (roll < 50) ? sqlsplit_pkg::CH_SQUOTE : sqlsplit_pkg::CH_DQUOTE;
      script_q.push_back(q);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(3) == 0) begin
          script_q.push_back(q);
          script_q.push_back(q);
        end else begin
          script_q.push_back(pick_other(q));
        end
      end
      script_q.push_back(q);
    end else if (roll < 63) begin
      script_q.push_back(sqlsplit_pkg::CH_DASH);
      script_q.push_back(sqlsplit_pkg::CH_DASH);
      for (int k = 0; k < len; k++) script_q.push_back(pick_other(sqlsplit_pkg::CH_NL));
      script_q.push_back(sqlsplit_pkg::CH_NL);
    end else if (roll < 70) begin
      script_q.push_back(sqlsplit_pkg::CH_SLASH);
      script_q.push_back(sqlsplit_pkg::CH_STAR);
      for (int k = 0; k < len; k++)
        script_q.push_back(($urandom_range(1) == 0) ? sqlsplit_pkg::CH_STAR
                                                    : pick_other(sqlsplit_pkg::CH_SLASH));
      script_q.push_back(sqlsplit_pkg::CH_STAR);
      script_q.push_back(sqlsplit_pkg::CH_SLASH);
    end else if (roll < 80) begin
      if ($urandom_range(1) == 0) script_q.push_back(pick_blank());
      script_q.push_back(sqlsplit_pkg::CH_SEMI);
    end else if (roll < 88) begin
      case ($urandom_range(2))
        0:       script_q.push_back(sqlsplit_pkg::CH_DASH);
        1:       script_q.push_back(sqlsplit_pkg::CH_SLASH);
        default: script_q.push_back(sqlsplit_pkg::CH_STAR);
      endcase
    end else begin
      for (int k = 0; k <= len % 3; k++) script_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void build_script();
    int n;
    n = $urandom_range(2, 10);
    for (int t = 0; t < n; t++) add_token();
    // some scripts stop in the middle of a token
    if ($urandom_range(7) == 0 && script_q.size() > 1)
      script_q = script_q[0:$urandom_range(script_q.size() - 2)];
  endfunction

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int rand_base;
    int phase;
    idle_tab  = '{0, 71, 0, 11};
    stall_tab = '{0, 0, 71, 11};
    idle_pct            = 0;
    stall_pct           = 0;
    bytes_sent          = 0;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.script_byte = 8'h00;
    in_chan.is_final    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("-a/b--\n/***/''''\"\" ;;", 1'b0);
    send_text("-", 1'b1);
    send_text("''", 1'b1);
    send_text("\"x", 1'b1);
    send_text(";", 1'b1);
    drain();

    rand_base = bytes_sent;
    phase     = 0;
    while (bytes_sent - rand_base < 420) begin
      if ((bytes_sent - rand_base) / 105 != phase) begin
        phase = (bytes_sent - rand_base) / 105;
        drain();
        idle_pct  = idle_tab[phase];
        stall_pct = stall_tab[phase];
      end
      build_script();
      send_script();
    end
    stall_pct = 0;
    drain();

    if (fail_count == 0 && results_due == 0) begin
      $display("** sql_statement_splitter_top: PASSED **");
    end else begin
      $display("** sql_statement_splitter_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("** sql_statement_splitter_top: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sqlsplit_pkg.sv
rtl/core/sqlsplit_if.sv
rtl/core/sqlsplit_lexer.sv
rtl/core/sqlsplit_fifo.sv
rtl/core/sqlsplit_trim.sv
rtl/core/sql_statement_splitter_top.sv
test/sqlsplit_checker.sv
test/tb_top.sv
